@@ sv/cascade_reach_count_assert.svh @@
// Assertion macros for the cascade reach counter.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef CASCADE_REACH_COUNT_ASSERT_SVH
`define CASCADE_REACH_COUNT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/crc_pkg.sv @@
// Shared types and constants for the cascade reach counter.
// No dependencies.
package crc_pkg;

    localparam int NODE_COUNT = 256;
    localparam int NODE_W     = 8;
    localparam int Q_AW       = $clog2(NODE_COUNT);
    localparam int QPTR_W     = Q_AW + 1;
    localparam int COUNT_W    = 9;
    localparam int KIND_W     = 3;

    localparam int DEF_EDGE_CAPACITY = 2048;
    localparam int DEF_FRACTION_BITS = 16;

    localparam logic [KIND_W-1:0] KIND_ADD_EDGE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SEED     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DISABLE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RUN      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;

    // Per-edge context handed from the sequencer to the edge evaluator.
    typedef struct packed {
        logic              invert;
        logic              tgt_reached;
        logic [NODE_W-1:0] node;
    } t_eval_ctl;

endpackage

@@ sv/cascade_reach_count.sv @@
// Cascade reach counter top level: graph store, run sequencer, result register.
// Depends on crc_pkg, crc_ram, crc_edge_eval and cascade_reach_count_assert.svh.
//
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+--------------------------------------
//  input   | in        | i_valid / o_stall  | kind, nodes, prob, dice, mark, invert
//  result  | out       | o_valid / i_stall  | reached_count, edges_dropped
//
// Load, mark, clear and unused-kind beats are taken in the idle state.
// A run beat sweeps the seed marks into the work queue, then for each queued
// node reads the queue, walks the edges through the single edge RAM read
// port and drains, and finishes with an empty-queue check and the result
// hand-off.
// Synchronous active-low reset clears marks, edge_total and the dropped flag.
// A result waiting on i_stall does not block loads; a second run holds in its
// finish cycle until the previous result is taken.
module cascade_reach_count #(
    parameter int EDGE_CAPACITY = crc_pkg::DEF_EDGE_CAPACITY,
    parameter int FRACTION_BITS = crc_pkg::DEF_FRACTION_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [crc_pkg::KIND_W-1:0]  i_kind,
    input  logic [crc_pkg::NODE_W-1:0]  i_source_node,
    input  logic [crc_pkg::NODE_W-1:0]  i_target_node,
    input  logic [FRACTION_BITS:0]      i_edge_prob,
    input  logic [FRACTION_BITS:0]      i_edge_dice,
    input  logic                        i_mark,
    input  logic                        i_invert,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [crc_pkg::COUNT_W-1:0] o_reached_count,
    output logic                        o_edges_dropped
);
    import crc_pkg::*;

    localparam int VAL_W   = FRACTION_BITS + 1;
    localparam int EDGE_AW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
    localparam int ET_W    = $clog2(EDGE_CAPACITY + 1);
    localparam int EDGE_DW = 2 * NODE_W + 2 * VAL_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SEED = 3'd1;   // sweep seed marks into queue
    localparam logic [2:0] S_POP  = 3'd2;   // issue queue read or finish
    localparam logic [2:0] S_NODE = 3'd3;   // latch popped node
    localparam logic [2:0] S_WALK = 3'd4;   // walk edge store for that node
    localparam logic [2:0] S_FIN  = 3'd5;   // hand result to output register

    logic [2:0]            r_state,       n_state;
    logic [ET_W-1:0]       r_edge_total,  n_edge_total;
    logic                  r_dropped,     n_dropped;
    logic [NODE_COUNT-1:0] r_seed,        n_seed;
    logic [NODE_COUNT-1:0] r_dis,         n_dis;
    logic [NODE_COUNT-1:0] r_reached,     n_reached;
    logic [QPTR_W-1:0]     r_head,        n_head;
    logic [QPTR_W-1:0]     r_tail,        n_tail;
    logic [COUNT_W-1:0]    r_count,       n_count;
    logic [NODE_W-1:0]     r_sweep,       n_sweep;
    logic [NODE_W-1:0]     r_node,        n_node;
    logic [ET_W-1:0]       r_eaddr,       n_eaddr;
    logic                  r_eval_vld,    n_eval_vld;
    logic                  r_invert,      n_invert;
    logic                  r_out_vld,     n_out_vld;
    logic [COUNT_W-1:0]    r_out_count,   n_out_count;
    logic                  r_out_dropped, n_out_dropped;

    logic                  in_acc;
    logic                  out_take;
    logic                  src_ok;
    logic                  tgt_ok;
    logic                  more_edges;

    // Edge store
    logic                  e_we;
    logic [EDGE_DW-1:0]    e_wdata;
    logic [EDGE_DW-1:0]    e_rdata;
    logic [NODE_W-1:0]     e_src;
    logic [NODE_W-1:0]     e_tgt;
    logic [VAL_W-1:0]      e_prob;
    logic [VAL_W-1:0]      e_dice;

    // Work queue
    logic                  q_we;
    logic [NODE_W-1:0]     q_wdata;
    logic [NODE_W-1:0]     q_rdata;

    t_eval_ctl             eval_ctl;
    logic                  fire;

    assign in_acc     = i_valid && (r_state == S_IDLE);
    assign out_take   = r_out_vld && !i_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign src_ok     = ({1'b0, i_source_node} < (NODE_W + 1)'(NODE_COUNT));
    assign tgt_ok     = ({1'b0, i_target_node} < (NODE_W + 1)'(NODE_COUNT));
    assign more_edges = (r_eaddr < r_edge_total);

    assign e_wdata = {i_source_node, i_target_node, i_edge_prob, i_edge_dice};
    assign e_src   = e_rdata[EDGE_DW-1 -: NODE_W];
    assign e_tgt   = e_rdata[EDGE_DW-NODE_W-1 -: NODE_W];
    assign e_prob  = e_rdata[2*VAL_W-1 -: VAL_W];
    assign e_dice  = e_rdata[VAL_W-1:0];

    crc_ram #(
        .WIDTH (EDGE_DW),
        .DEPTH (EDGE_CAPACITY)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (r_edge_total[EDGE_AW-1:0]),
        .i_wdata (e_wdata),
        .i_raddr (r_eaddr[EDGE_AW-1:0]),
        .o_rdata (e_rdata)
    );

    // Queue read address is always the head; read data is registered by the RAM.
    crc_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_tail[Q_AW-1:0]),
        .i_wdata (q_wdata),
        .i_raddr (r_head[Q_AW-1:0]),
        .o_rdata (q_rdata)
    );

    assign eval_ctl.invert      = r_invert;
    assign eval_ctl.tgt_reached = r_reached[e_tgt];
    assign eval_ctl.node        = r_node;

    crc_edge_eval #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_eval (
        .i_edge_src  (e_src),
        .i_edge_prob (e_prob),
        .i_edge_dice (e_dice),
        .i_ctl       (eval_ctl),
        .o_fire      (fire)
    );

    always_comb begin
        n_state       = r_state;
        n_edge_total  = r_edge_total;
        n_dropped     = r_dropped;
        n_seed        = r_seed;
        n_dis         = r_dis;
        n_reached     = r_reached;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_sweep       = r_sweep;
        n_node        = r_node;
        n_eaddr       = r_eaddr;
        n_eval_vld    = 1'b0;
        n_invert      = r_invert;
        n_out_vld     = r_out_vld && !out_take;
        n_out_count   = r_out_count;
        n_out_dropped = r_out_dropped;
        e_we          = 1'b0;
        q_we          = 1'b0;
        q_wdata       = r_sweep;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_kind)
                        KIND_ADD_EDGE: begin
                            if (src_ok && tgt_ok) begin
                                if (r_edge_total >= ET_W'(EDGE_CAPACITY)) begin
                                    n_dropped = 1'b1;
                                end else begin
                                    e_we         = 1'b1;
                                    n_edge_total = r_edge_total + ET_W'(1);
                                end
                            end
                        end
                        KIND_SEED: begin
                            if (src_ok) begin
                                n_seed[i_source_node] = i_mark;
                            end
                        end
                        KIND_DISABLE: begin
                            if (src_ok) begin
                                n_dis[i_source_node] = i_mark;
                            end
                        end
                        KIND_RUN: begin
                            // disabled nodes count as already reached
                            n_invert  = i_invert;
                            n_reached = r_seed | r_dis;
                            n_head    = '0;
                            n_tail    = '0;
                            n_count   = '0;
                            n_sweep   = '0;
                            n_state   = S_SEED;
                        end
                        KIND_CLEAR: begin
                            n_edge_total = '0;
                            n_seed       = '0;
                            n_dis        = '0;
                            n_reached    = '0;
                            n_dropped    = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEED: begin
                if (r_seed[r_sweep] && !r_dis[r_sweep]) begin
                    q_we   = 1'b1;
                    n_tail = r_tail + QPTR_W'(1);
                end
                if (r_sweep == NODE_W'(NODE_COUNT - 1)) begin
                    n_state = S_POP;
                end else begin
                    n_sweep = r_sweep + NODE_W'(1);
                end
            end
            S_POP: begin
                if (r_head == r_tail) begin
                    n_state = S_FIN;
                end else begin
                    n_head  = r_head + QPTR_W'(1);
                    n_state = S_NODE;
                end
            end
            S_NODE: begin
                n_node  = q_rdata;
                n_eaddr = '0;
                n_state = S_WALK;
            end
            S_WALK: begin
                // issue one edge read per cycle, evaluate the one from last cycle
                if (more_edges) begin
                    n_eaddr    = r_eaddr + ET_W'(1);
                    n_eval_vld = 1'b1;
                end
                if (r_eval_vld && fire) begin
                    n_reached[e_tgt] = 1'b1;
                    q_we             = 1'b1;
                    q_wdata          = e_tgt;
                    n_tail           = r_tail + QPTR_W'(1);
                    n_count          = r_count + COUNT_W'(1);
                end
                if (!more_edges) begin
                    n_state = S_POP;
                end
            end
            S_FIN: begin
                if (!r_out_vld || out_take) begin
                    n_out_vld     = 1'b1;
                    n_out_count   = r_count;
                    n_out_dropped = r_dropped;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_edge_total <= '0;
            r_dropped    <= 1'b0;
            r_seed       <= '0;
            r_dis        <= '0;
            r_reached    <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_sweep      <= '0;
            r_eaddr      <= '0;
            r_eval_vld   <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_edge_total <= n_edge_total;
            r_dropped    <= n_dropped;
            r_seed       <= n_seed;
            r_dis        <= n_dis;
            r_reached    <= n_reached;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_sweep      <= n_sweep;
            r_eaddr      <= n_eaddr;
            r_eval_vld   <= n_eval_vld;
            r_out_vld    <= n_out_vld;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_node        <= n_node;
        r_invert      <= n_invert;
        r_out_count   <= n_out_count;
        r_out_dropped <= n_out_dropped;
    end

    assign o_valid         = r_out_vld;
    assign o_reached_count = r_out_count;
    assign o_edges_dropped = r_out_dropped;

`include "cascade_reach_count_assert.svh"

    `CRC_ASSERT_NOW(a_queue_order, 1'b1, r_head <= r_tail, "queue head passed tail")
    `CRC_ASSERT_NOW(a_count_le_tail, 1'b1, QPTR_W'(r_count) <= r_tail,
        "reached count exceeds queued nodes")
    `CRC_ASSERT_NOW(a_edge_total_cap, 1'b1, r_edge_total <= ET_W'(EDGE_CAPACITY),
        "edge total beyond capacity")
    `CRC_ASSERT_NOW(a_eval_in_walk, r_eval_vld, r_state == S_WALK,
        "edge evaluation outside the walk")
    `CRC_ASSERT_NEXT(a_fin_hands_off, (r_state == S_FIN) && !r_out_vld, r_out_vld,
        "finished run did not load the result")

endmodule

@@ sv/crc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module crc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/crc_edge_eval.sv @@
// Edge evaluator: decides whether one stored edge fires from the current node.
// Depends on crc_pkg.
module crc_edge_eval #(
    parameter int FRACTION_BITS = crc_pkg::DEF_FRACTION_BITS
) (
    input  logic [crc_pkg::NODE_W-1:0] i_edge_src,
    input  logic [FRACTION_BITS:0]     i_edge_prob,
    input  logic [FRACTION_BITS:0]     i_edge_dice,
    input  crc_pkg::t_eval_ctl         i_ctl,
    output logic                       o_fire
);
    import crc_pkg::*;

    // Two spare bits cover one minus dice going negative.
    localparam int CW = FRACTION_BITS + 3;

    logic [CW-1:0] one_x;
    logic [CW-1:0] dice_x;
    logic [CW-1:0] prob_x;
    logic [CW-1:0] thr_x;

    assign one_x  = CW'(1) << FRACTION_BITS;
    assign dice_x = CW'(i_edge_dice);
    assign prob_x = CW'(i_edge_prob);
    assign thr_x  = i_ctl.invert ? (one_x - dice_x) : dice_x;

    assign o_fire = (i_edge_src == i_ctl.node) && !i_ctl.tgt_reached
                    && ($signed(prob_x) > $signed(thr_x));

endmodule

@@ tb/cascade_reach_count_tb.sv @@
// Self-checking testbench for the cascade reach counter: directed table, store-full
// fill, then random graph episodes, scored by an in-bench cascade predictor or typed rows.
// Depends on crc_pkg and the cascade_reach_count RTL only.
module cascade_reach_count_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crc_pkg::*;

    localparam int EDGE_CAP     = DEF_EDGE_CAPACITY;
    localparam int FRAC_BITS    = DEF_FRACTION_BITS;
    localparam int Q_ONE        = 1 << FRAC_BITS;
    localparam int RANDOM_ITEMS = 250;
    localparam int MAX_GAP      = 18;
    localparam int HOLD_CYCLES  = 1500;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 64;     // quiet time after the last result
    localparam int POOL_MAX     = 16;
    localparam int FILL_POOL    = 8;
    localparam int EXP_DEPTH    = 16;     // expected results in flight, ring

    // Kinds the block ignores.
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    typedef logic [FRAC_BITS:0] t_q;

    // One input beat plus an optional hand-typed expectation for run beats.
    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [NODE_W-1:0]  src;
        logic [NODE_W-1:0]  tgt;
        t_q                 prob;
        t_q                 dice;
        logic               mark;
        logic               inv;
        bit                 typed;
        logic [COUNT_W-1:0] typed_count;
        logic               typed_drop;
    } t_graph_beat;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               dropped;
    } t_reach_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [KIND_W-1:0]  i_kind;
    logic [NODE_W-1:0]  i_source_node;
    logic [NODE_W-1:0]  i_target_node;
    t_q                 i_edge_prob;
    t_q                 i_edge_dice;
    logic               i_mark;
    logic               i_invert;
    logic               o_valid;
    logic               i_stall;
    logic [COUNT_W-1:0] o_reached_count;
    logic               o_edges_dropped;

    // The payload ports follow the beat register, which is written once per offered beat.
    t_graph_beat cur_beat;

    assign i_kind        = cur_beat.kind;
    assign i_source_node = cur_beat.src;
    assign i_target_node = cur_beat.tgt;
    assign i_edge_prob   = cur_beat.prob;
    assign i_edge_dice   = cur_beat.dice;
    assign i_mark        = cur_beat.mark;
    assign i_invert      = cur_beat.inv;

    cascade_reach_count #(
        .EDGE_CAPACITY (EDGE_CAP),
        .FRACTION_BITS (FRAC_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_source_node   (i_source_node),
        .i_target_node   (i_target_node),
        .i_edge_prob     (i_edge_prob),
        .i_edge_dice     (i_edge_dice),
        .i_mark          (i_mark),
        .i_invert        (i_invert),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_reached_count (o_reached_count),
        .o_edges_dropped (o_edges_dropped)
    );

    // ---------------------------------------------------------------------
    // Predictor state: a shadow of the graph, the node marks and the drop flag.
    // ---------------------------------------------------------------------
    logic [NODE_W-1:0] shadow_src  [EDGE_CAP];
    logic [NODE_W-1:0] shadow_tgt  [EDGE_CAP];
    t_q                shadow_prob [EDGE_CAP];
    t_q                shadow_dice [EDGE_CAP];
    int                shadow_edge_total;
    bit                shadow_seed     [NODE_COUNT];
    bit                shadow_disabled [NODE_COUNT];
    bit                shadow_dropped;

    // Expected results in order, as a ring with free-running indexes.
    t_reach_result exp_ring [EXP_DEPTH];
    int            exp_wr     = 0;
    int            exp_rd     = 0;
    int            fail_count = 0;

    // Shared between the sender and the result sink.
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(100_000_000);
        $display("%0t: timeout, %0d results still pending", $time, exp_wr - exp_rd);
        $display("Some tests failed");
        $finish;
    end

    // Breadth-first cascade over the shadow graph. Disabled nodes count as
    // already reached, so they never enter; a disabled seed does not spread.
    // The threshold is signed: an inverted dice above one goes negative.
    function automatic logic [COUNT_W-1:0] predict_reach_count(input logic inv);
        bit                 reached  [NODE_COUNT];
        int                 frontier [NODE_COUNT];
        int                 head;
        int                 tail;
        int                 node;
        int                 tgt;
        int                 thresh;
        logic [COUNT_W-1:0] count;
        head  = 0;
        tail  = 0;
        count = '0;
        for (int n = 0; n < NODE_COUNT; n++) begin
            reached[n] = shadow_seed[n] || shadow_disabled[n];
            if (shadow_seed[n] && !shadow_disabled[n]) begin
                frontier[tail] = n;
                tail++;
            end
        end
        while (head < tail) begin
            node = frontier[head];
            head++;
            // Edges are tried in load order, duplicates each on their own.
            for (int e = 0; e < shadow_edge_total; e++) begin
                tgt    = int'(shadow_tgt[e]);
                thresh = inv ? Q_ONE - int'(shadow_dice[e]) : int'(shadow_dice[e]);
                if (int'(shadow_src[e]) == node && !reached[tgt]
                        && int'(shadow_prob[e]) > thresh) begin
                    reached[tgt]   = 1'b1;
                    frontier[tail] = tgt;
                    tail++;
                    count++;
                end
            end
        end
        return count;
    endfunction

    // ---------------------------------------------------------------------
    // Scoreboard: sample both handshakes at the edge, pre-update values only.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_reach_result want;
        if (i_rst_n && i_valid && !o_stall) begin
            case (cur_beat.kind)
                KIND_ADD_EDGE: begin
                    if (shadow_edge_total >= EDGE_CAP) begin
                        shadow_dropped = 1'b1;   // store full, load lost
                    end else begin
                        shadow_src[shadow_edge_total]  = cur_beat.src;
                        shadow_tgt[shadow_edge_total]  = cur_beat.tgt;
                        shadow_prob[shadow_edge_total] = cur_beat.prob;
                        shadow_dice[shadow_edge_total] = cur_beat.dice;
                        shadow_edge_total++;
                    end
                end
                KIND_SEED:    shadow_seed[cur_beat.src]     = cur_beat.mark;
                KIND_DISABLE: shadow_disabled[cur_beat.src] = cur_beat.mark;
                KIND_RUN: begin
                    want.count   = predict_reach_count(cur_beat.inv);
                    want.dropped = shadow_dropped;
                    if (cur_beat.typed) begin
                        want.count   = cur_beat.typed_count;
                        want.dropped = cur_beat.typed_drop;
                    end
                    exp_ring[exp_wr % EXP_DEPTH] = want;
                    exp_wr++;
                end
                KIND_CLEAR: begin
                    shadow_edge_total = 0;
                    shadow_dropped    = 1'b0;
                    for (int n = 0; n < NODE_COUNT; n++) begin
                        shadow_seed[n]     = 1'b0;
                        shadow_disabled[n] = 1'b0;
                    end
                end
                default: ;   // spare kinds do nothing
            endcase
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (exp_wr == exp_rd) begin
                $display("%0t: unexpected result, expected none, actual count %0d dropped %0d",
                         $time, o_reached_count, o_edges_dropped);
                fail_count++;
            end else begin
                want = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_reached_count !== want.count) begin
                    $display("%0t: reached_count mismatch, expected %0d, actual %0d",
                             $time, want.count, o_reached_count);
                    fail_count++;
                end
                if (o_edges_dropped !== want.dropped) begin
                    $display("%0t: edges_dropped mismatch, expected %0d, actual %0d",
                             $time, want.dropped, o_edges_dropped);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result sink: random stall gaps per beat, plus one long hold on request.
    // ---------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        i_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    // ---------------------------------------------------------------------
    // Sender helpers.
    // ---------------------------------------------------------------------
    function automatic t_graph_beat beat_of(input logic [KIND_W-1:0] kind,
                                            input logic [NODE_W-1:0] src,
                                            input logic [NODE_W-1:0] tgt,
                                            input t_q prob, input t_q dice,
                                            input logic mark, input logic inv);
        t_graph_beat b;
        b.kind        = kind;
        b.src         = src;
        b.tgt         = tgt;
        b.prob        = prob;
        b.dice        = dice;
        b.mark        = mark;
        b.inv         = inv;
        b.typed       = 1'b0;
        b.typed_count = '0;
        b.typed_drop  = 1'b0;
        return b;
    endfunction

    function automatic logic [NODE_W-1:0] rand_node();
        return NODE_W'($urandom_range(0, NODE_COUNT - 1));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Mostly in-range Q1.16, with the extremes and the full 17-bit span mixed in.
    function automatic t_q rand_q();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return t_q'(Q_ONE);
            2:       return t_q'(Q_ONE - 1);
            3:       return '1;
            4, 5:    return t_q'($urandom_range(0, 2 * Q_ONE - 1));
            default: return t_q'($urandom_range(0, Q_ONE));
        endcase
    endfunction

    // Offer one beat after an optional idle gap; returns at the accepting edge.
    task automatic offer(input t_graph_beat b);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        cur_beat <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Stop offering until every pending result is back.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (exp_wr != exp_rd) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Directed table. Run rows with typed=1 carry an obvious answer; the
    // rest go through the predictor. Fields: kind, src, tgt, prob, dice,
    // mark, invert, typed, count, dropped.
    // ---------------------------------------------------------------------
    t_graph_beat directed_tbl [24] = '{
        // nothing loaded yet
        '{KIND_RUN,     8'd0,   8'd0,   17'd0,     17'd0,     1'b0, 1'b0, 1'b1, 9'd0, 1'b0},
        '{KIND_SEED,    8'd0,   8'd0,   17'd0,     17'd0,     1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
        // a seed with no edges reaches nobody
        '{KIND_RUN,     8'd0,   8'd0,   17'd0,     17'd0,     1'b0, 1'b1, 1'b1, 9'd0, 1'b0},
        // prob one against dice just below one fires
        '{KIND_ADD_EDGE, 8'd0,  8'd255, 17'h10000, 17'h0ffff, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{KIND_ADD_EDGE, 8'd255, 8'd128, 17'd0,    17'd0,     1'b1, 1'b1, 1'b0, 9'd0, 1'b0},
        // duplicate edge, own prob and dice
        '{KIND_ADD_EDGE, 8'd255, 8'd128, 17'd1,    17'd0,     1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        // back into the seed: already reached
        '{KIND_ADD_EDGE, 8'd128, 8'd0,  17'h1ffff, 17'h1ffff, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        // inverted dice goes negative, so prob zero still fires
        '{KIND_ADD_EDGE, 8'd128, 8'd170, 17'd0,    17'h1ffff, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{KIND_ADD_EDGE, 8'd170, 8'd85, 17'h10000, 17'h10000, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{KIND_RUN,     8'd0,   8'd0,   17'd0,     17'd0,     1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{KIND_RUN,     8'hff,  8'hff,  17'h1ffff, 17'h1ffff, 1'b1, 1'b1, 1'b0, 9'd0, 1'b0},
        // disabled node blocks the path
        '{KIND_DISABLE, 8'd255, 8'd0,   17'd0,     17'd0,     1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
        '{KIND_RUN,     8'd0,   8'd0,   17'd0,     17'd0,     1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        // seed that is also disabled
        '{KIND_DISABLE, 8'd0,   8'd0,   17'd0,     17'd0,     1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
        '{KIND_RUN,     8'd0,   8'd0,   17'd0,     17'd0,     1'b0, 1'b1, 1'b0, 9'd0, 1'b0},
        '{KIND_DISABLE, 8'd0,   8'd0,   17'd0,     17'd0,     1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{KIND_DISABLE, 8'd255, 8'd0,   17'd0,     17'd0,     1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{KIND_SEED,    8'd0,   8'd0,   17'd0,     17'd0,     1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        '{KIND_SEED,    8'd170, 8'd0,   17'd0,     17'd0,     1'b1, 1'b0, 1'b0, 9'd0, 1'b0},
        // spare kinds: ignored, no result
        '{KIND_SPARE_FIRST, 8'hff, 8'hff, 17'h1ffff, 17'h1ffff, 1'b1, 1'b1, 1'b0, 9'd0, 1'b0},
        '{KIND_SPARE_LAST,  8'hff, 8'hff, 17'h1ffff, 17'h1ffff, 1'b1, 1'b1, 1'b0, 9'd0, 1'b0},
        '{KIND_RUN,     8'd0,   8'd0,   17'd0,     17'd0,     1'b0, 1'b1, 1'b0, 9'd0, 1'b0},
        '{KIND_CLEAR,   8'd0,   8'd0,   17'd0,     17'd0,     1'b0, 1'b0, 1'b0, 9'd0, 1'b0},
        // everything gone after clear
        '{KIND_RUN,     8'd0,   8'd0,   17'd0,     17'd0,     1'b0, 1'b0, 1'b1, 9'd0, 1'b0}
    };

    // ---------------------------------------------------------------------
    // Stimulus.
    // ---------------------------------------------------------------------
    initial begin : stimulus
        logic [NODE_W-1:0] pool [POOL_MAX];
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] tgt;
        logic [KIND_W-1:0] mark_kind;
        int                rand_items;
        int                ep;
        int                pool_n;
        int                n_edges;
        int                n_marks;
        int                n_runs;
        int                edges_since_clear;

        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        cur_beat <= beat_of(KIND_ADD_EDGE, '0, '0, '0, '0, 1'b0, 1'b0);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_tbl[r])
            offer(directed_tbl[r]);

        // Store full: fill to capacity, then two loads that must be dropped.
        // Only the first few edges can fire, which keeps the runs short.
        idle_on = 1'b0;
        offer(beat_of(KIND_CLEAR, '0, '0, '0, '0, 1'b0, 1'b0));
        for (int i = 0; i < FILL_POOL; i++)
            pool[i] = rand_node();
        for (int e = 0; e < EDGE_CAP + 2; e++) begin
            if (e < FILL_POOL)
                offer(beat_of(KIND_ADD_EDGE, pool[$urandom_range(0, FILL_POOL - 1)],
                              pool[$urandom_range(0, FILL_POOL - 1)], rand_q(), rand_q(),
                              rand_bit(), rand_bit()));
            else
                offer(beat_of(KIND_ADD_EDGE, rand_node(), rand_node(), '0, '0,
                              rand_bit(), rand_bit()));
        end
        offer(beat_of(KIND_SEED, pool[0], '0, '0, '0, 1'b1, 1'b0));
        offer(beat_of(KIND_RUN, '0, '0, '0, '0, 1'b0, 1'b0));
        idle_on = 1'b1;
        offer(beat_of(KIND_RUN, '0, '0, '0, '0, 1'b0, 1'b1));
        offer(beat_of(KIND_CLEAR, '0, '0, '0, '0, 1'b0, 1'b0));

        // Random episodes: small node pools so cascades actually travel,
        // some noise and out-of-order runs mixed in.
        rand_items        = 0;
        ep                = 0;
        edges_since_clear = 0;
        while (rand_items < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (edges_since_clear > 40 || $urandom_range(0, 4) != 0) begin
                offer(beat_of(KIND_CLEAR, rand_node(), rand_node(), rand_q(), rand_q(),
                              rand_bit(), rand_bit()));
                rand_items++;
                edges_since_clear = 0;
            end
            pool_n = $urandom_range(2, POOL_MAX);
            for (int i = 0; i < pool_n; i++)
                pool[i] = rand_node();

            // run before the graph is built
            if ($urandom_range(0, 6) == 0) begin
                offer(beat_of(KIND_RUN, rand_node(), rand_node(), rand_q(), rand_q(),
                              rand_bit(), rand_bit()));
                rand_items++;
            end

            n_edges = $urandom_range(0, 24);
            for (int i = 0; i < n_edges; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    src = rand_node();
                    tgt = rand_node();
                end else begin
                    src = pool[$urandom_range(0, pool_n - 1)];
                    tgt = pool[$urandom_range(0, pool_n - 1)];
                end
                offer(beat_of(KIND_ADD_EDGE, src, tgt, rand_q(), rand_q(),
                              rand_bit(), rand_bit()));
                rand_items++;
                edges_since_clear++;
                if ($urandom_range(0, 19) == 0)
                    offer(beat_of(KIND_W'(KIND_SPARE_FIRST +
                                  $urandom_range(0, KIND_SPARE_LAST - KIND_SPARE_FIRST)),
                                  rand_node(), rand_node(), rand_q(), rand_q(),
                                  rand_bit(), rand_bit()));
            end

            n_marks = $urandom_range(1, 4);
            for (int i = 0; i < n_marks; i++) begin
                mark_kind = ($urandom_range(0, 2) == 0) ? KIND_DISABLE : KIND_SEED;
                offer(beat_of(mark_kind, pool[$urandom_range(0, pool_n - 1)], rand_node(),
                              rand_q(), rand_q(), ($urandom_range(0, 4) != 0), rand_bit()));
                rand_items++;
            end

            if (ep == 4) begin
                // Receiver holds off; back-to-back runs and loads fill the block
                // until it stalls the input.
                idle_on  = 1'b0;
                hold_req = 1'b1;
                for (int i = 0; i < 3; i++)
                    offer(beat_of(KIND_RUN, '0, '0, '0, '0, 1'b0, rand_bit()));
                for (int i = 0; i < 6; i++)
                    offer(beat_of(KIND_SEED, pool[$urandom_range(0, pool_n - 1)], '0,
                                  '0, '0, rand_bit(), 1'b0));
                offer(beat_of(KIND_RUN, '0, '0, '0, '0, 1'b0, rand_bit()));
                rand_items += 10;
            end else begin
                n_runs = $urandom_range(1, 3);
                for (int i = 0; i < n_runs; i++) begin
                    offer(beat_of(KIND_RUN, rand_node(), rand_node(), rand_q(), rand_q(),
                                  rand_bit(), rand_bit()));
                    rand_items++;
                    if ($urandom_range(0, 2) == 0) begin
                        offer(beat_of(KIND_SEED, pool[$urandom_range(0, pool_n - 1)], '0,
                                      '0, '0, rand_bit(), 1'b0));
                        rand_items++;
                    end
                end
            end

            // sender pause until the block has handed back everything
            if (ep == 9)
                drain_results();
            ep++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
